/* sv/floating_horizon_hidden_line_assert.svh */
// assertion macros for the hidden-line block
`ifndef FLOATING_HORIZON_HIDDEN_LINE_ASSERT_SVH
`define FLOATING_HORIZON_HIDDEN_LINE_ASSERT_SVH
`ifndef ASSERT_OFF
// condition must hold in the same cycle
`define FHHL_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("hidden-line check failed");
// condition must hold in the following cycle
`define FHHL_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("hidden-line check failed");
`else
`define FHHL_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons)
`define FHHL_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons)
`endif
`endif

/* sv/fhhl_pkg.sv */
package fhhl_pkg;

	localparam int COORD_W   = 10;
	localparam int COLS      = 1024;
	localparam int COL_W     = 10;
	localparam int INC_W     = 10;
	localparam int DIV_NUM_W = 22;
	localparam int DIV_DEN_W = 11;

	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [0:0] {
		OP_DRAW  = 1'b0,
		OP_CLEAR = 1'b1
	} opcode_t;

	typedef struct packed {
		logic   opcode;
		coord_t start_x;
		coord_t start_y;
		coord_t end_x;
		coord_t end_y;
	} item_t;

	typedef struct packed {
		coord_t piece_x0;
		coord_t piece_y0;
		coord_t piece_x1;
		coord_t piece_y1;
		logic   last_piece;
		logic   span_error;
	} piece_t;

	// point class against the two horizons
	typedef enum logic [1:0] {
		CL_HIDDEN,
		CL_ABOVE,
		CL_BELOW
	} cls_t;

	// what one walk step does
	typedef enum logic [2:0] {
		MD_NONE,
		MD_DIRECT,
		MD_CUT_END,
		MD_CUT_START,
		MD_DOUBLE
	} mode_t;

	// end points of the emitted piece: previous, intersection, current
	typedef enum logic [1:0] {
		FM_PC,
		FM_PI,
		FM_IC
	} form_t;

	typedef enum logic [0:0] {
		HZ_UPPER,
		HZ_LOWER
	} hz_sel_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_DECODE,
		S_P_CLS,
		S_STEP,
		S_STEP_WAIT,
		S_C_RD,
		S_C_CLS,
		S_CR_RD0,
		S_CR_CHK0,
		S_CR_NEXT,
		S_CR_WAIT,
		S_CR_RD,
		S_CR_CHK,
		S_EMIT,
		S_SW_X,
		S_SW_WAIT,
		S_SW_RD,
		S_SW_WR,
		S_AFTER,
		S_ADV,
		S_FIN,
		S_ERR
	} fsm_t;

	typedef enum logic [2:0] {
		DV_IDLE,
		DV_MUL,
		DV_PREP,
		DV_ITER,
		DV_DONE
	} div_state_t;

	typedef struct packed {
		logic   start;
		coord_t xa;
		coord_t ya;
		coord_t xb;
		coord_t yb;
		coord_t x;
	} div_req_t;

	typedef struct packed {
		logic   busy;
		logic   done;
		coord_t y;
	} div_rsp_t;

endpackage

/* sv/floating_horizon_hidden_line.sv */
// Floating-horizon hidden-line removal for screen line segments.
// Input channel item (item_valid / item_stall): one draw or clear request,
// taken when item_valid is high and item_stall low. Segments go front to back.
// Output channel piece (piece_valid / piece_stall): visible pieces of the
// segment in walk order, the last one flagged by last_piece; a segment that
// needs more than MAX_STEPS steps gives one piece with span_error set.
// Config channel (cfg_valid / cfg_ready): step_increment, always ready.
// Horizons live in two 1024-entry RAMs; every column of a piece is read and
// then written back, and every interpolated row goes through one shared
// rounding divider. The time of a draw grows with its steps, with the columns
// crossed by a horizon search and with the columns of each emitted piece.
// One request is worked on at a time; the next is taken as soon as the last
// piece sits in the output register, even while the receiver stalls it.
// Reset (arst_n low) sets step_increment to 1 and starts a pass
// clearing both horizons; no request is taken until it is done. While the
// receiver stalls, the output register holds its piece, a pending register
// holds the next one and the walk waits at the piece after that.
`include "floating_horizon_hidden_line_assert.svh"

module floating_horizon_hidden_line #(
	parameter int SCREEN_SIZE = 1024,
	parameter int MAX_STEPS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [fhhl_pkg::INC_W-1:0]    cfg_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  fhhl_pkg::item_t               item,
	output logic                          piece_valid,
	input  logic                          piece_stall,
	output fhhl_pkg::piece_t              piece
);

	localparam int CW    = fhhl_pkg::COORD_W;
	localparam int AW    = fhhl_pkg::COL_W;
	localparam int IW    = fhhl_pkg::INC_W;
	localparam int HZ_W  = ($clog2(SCREEN_SIZE + 1) > 11) ? $clog2(SCREEN_SIZE + 1) : 11;
	localparam int LIM_W = $clog2(MAX_STEPS * 1024);

	fhhl_pkg::fsm_t state_q, state_d;
	logic [IW-1:0]  inc_q;
	logic [AW-1:0]  clr_q;
	logic           pend_v_q, out_v_q;

	fhhl_pkg::item_t  item_q;
	fhhl_pkg::piece_t pend_q, out_q;
	logic [CW-1:0]    px_q, py_q, cx_q, cy_q, ix_q, iy_q, cr_x_q, cr_y_q;
	logic [CW-1:0]    ea_x_q, ea_y_q, eb_x_q, eb_y_q, sw_x_q, sw_y_q;
	fhhl_pkg::cls_t   pf_q, cf_q;
	fhhl_pkg::mode_t  mode_q;
	fhhl_pkg::form_t  form_q;
	fhhl_pkg::hz_sel_t hz_sel_q, hz1_q;
	logic             dir_q, fin_q, vert_q, side_q, ph_q;

	fhhl_pkg::div_req_t div_req;
	fhhl_pkg::div_rsp_t div_rsp;

	logic            ram_we;
	logic [AW-1:0]   ram_addr;
	logic [HZ_W-1:0] up_rd, lo_rd, up_wd, lo_wd;

	logic [IW-1:0]    inc_eff;
	logic [CW-1:0]    adx;
	logic [LIM_W-1:0] step_lim;
	logic             too_many;
	logic [CW:0]      fwd_sum, bwd_lim;
	logic             step_fin;
	logic [CW-1:0]    step_cx, cr_nx, sw_nx;
	logic [CW-1:0]    cls_y;
	logic [HZ_W-1:0]  cls_yx, hz_rd, cr_yx;
	fhhl_pkg::cls_t   cls;
	fhhl_pkg::mode_t  mode_d;
	fhhl_pkg::form_t  form_d;
	fhhl_pkg::hz_sel_t hz0_d, hz1_d;
	logic             chk0_hit, chk_term, sw_need_div;
	fhhl_pkg::piece_t emit_piece, out_next;
	logic             out_free, push_ok, out_load;
	logic             item_acc;

	fhhl_ram #(.WIDTH(HZ_W), .DEPTH(fhhl_pkg::COLS)) u_upper (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (up_wd),
		.raddr (ram_addr),
		.rdata (up_rd)
	);

	fhhl_ram #(.WIDTH(HZ_W), .DEPTH(fhhl_pkg::COLS)) u_lower (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (lo_wd),
		.raddr (ram_addr),
		.rdata (lo_rd)
	);

	fhhl_interp u_interp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// step size, span check and next step column
	always_comb begin
		inc_eff  = (inc_q == '0) ? IW'(1) : inc_q;
		adx      = (item_q.end_x >= item_q.start_x) ? (item_q.end_x - item_q.start_x)
		                                             : (item_q.start_x - item_q.end_x);
		step_lim = LIM_W'(MAX_STEPS) * LIM_W'(inc_eff);
		too_many = LIM_W'(adx) > step_lim;
		fwd_sum  = {1'b0, px_q} + {1'b0, inc_eff};
		bwd_lim  = {1'b0, item_q.end_x} + {1'b0, inc_eff};
		step_fin = dir_q ? (fwd_sum >= {1'b0, item_q.end_x}) : ({1'b0, px_q} <= bwd_lim);
		if (step_fin) step_cx = item_q.end_x;
		else if (dir_q) step_cx = fwd_sum[CW-1:0];
		else step_cx = px_q - inc_eff;
		cr_nx = dir_q ? (cr_x_q + 1'b1) : (cr_x_q - 1'b1);
		sw_nx = (eb_x_q > ea_x_q) ? (sw_x_q + 1'b1) : (sw_x_q - 1'b1);
	end

	// classification against the horizons just read
	always_comb begin
		cls_y  = (state_q == fhhl_pkg::S_P_CLS) ? py_q : cy_q;
		cls_yx = HZ_W'(cls_y);
		if (cls_yx < up_rd && cls_yx > lo_rd) cls = fhhl_pkg::CL_HIDDEN;
		else if (cls_yx >= up_rd) cls = fhhl_pkg::CL_ABOVE;
		else cls = fhhl_pkg::CL_BELOW;
		hz_rd    = (hz_sel_q == fhhl_pkg::HZ_UPPER) ? up_rd : lo_rd;
		cr_yx    = HZ_W'(cr_y_q);
		chk0_hit = HZ_W'(py_q) == hz_rd;
		chk_term = ((cr_yx >= hz_rd) != side_q) || (cr_x_q == cx_q);
		sw_need_div = (sw_x_q != eb_x_q) && (sw_x_q != ea_x_q);
	end

	// what to do with the step from the previous to the current point
	always_comb begin
		mode_d = fhhl_pkg::MD_NONE;
		form_d = fhhl_pkg::FM_PC;
		hz0_d  = fhhl_pkg::HZ_UPPER;
		hz1_d  = fhhl_pkg::HZ_LOWER;
		if (cls == pf_q) begin
			mode_d = (cls != fhhl_pkg::CL_HIDDEN) ? fhhl_pkg::MD_DIRECT : fhhl_pkg::MD_NONE;
		end else if (cls == fhhl_pkg::CL_HIDDEN) begin
			mode_d = fhhl_pkg::MD_CUT_END;
			form_d = fhhl_pkg::FM_PI;
			hz0_d  = (pf_q == fhhl_pkg::CL_ABOVE) ? fhhl_pkg::HZ_UPPER : fhhl_pkg::HZ_LOWER;
		end else if (pf_q == fhhl_pkg::CL_HIDDEN) begin
			mode_d = fhhl_pkg::MD_CUT_START;
			form_d = fhhl_pkg::FM_IC;
			hz0_d  = (cls == fhhl_pkg::CL_ABOVE) ? fhhl_pkg::HZ_UPPER : fhhl_pkg::HZ_LOWER;
		end else if (cls == fhhl_pkg::CL_ABOVE) begin
			mode_d = fhhl_pkg::MD_DOUBLE;
			form_d = fhhl_pkg::FM_PI;
			hz0_d  = fhhl_pkg::HZ_LOWER;
			hz1_d  = fhhl_pkg::HZ_UPPER;
		end else begin
			mode_d = fhhl_pkg::MD_DOUBLE;
			form_d = fhhl_pkg::FM_PI;
		end
	end

	// piece assembly and output register feed
	always_comb begin
		emit_piece = '0;
		case (form_q)
			fhhl_pkg::FM_PI: begin
				emit_piece.piece_x0 = px_q;
				emit_piece.piece_y0 = py_q;
				emit_piece.piece_x1 = ix_q;
				emit_piece.piece_y1 = iy_q;
			end
			fhhl_pkg::FM_IC: begin
				emit_piece.piece_x0 = ix_q;
				emit_piece.piece_y0 = iy_q;
				emit_piece.piece_x1 = cx_q;
				emit_piece.piece_y1 = cy_q;
			end
			default: begin
				emit_piece.piece_x0 = px_q;
				emit_piece.piece_y0 = py_q;
				emit_piece.piece_x1 = cx_q;
				emit_piece.piece_y1 = cy_q;
			end
		endcase
		out_free = !out_v_q || !piece_stall;
		push_ok  = !pend_v_q || out_free;
		out_load = (((state_q == fhhl_pkg::S_EMIT) || (state_q == fhhl_pkg::S_FIN))
		            && pend_v_q && out_free)
		           || ((state_q == fhhl_pkg::S_ERR) && out_free);
		if (state_q == fhhl_pkg::S_ERR) begin
			out_next            = '0;
			out_next.last_piece = 1'b1;
			out_next.span_error = 1'b1;
		end else begin
			out_next            = pend_q;
			out_next.last_piece = state_q == fhhl_pkg::S_FIN;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fhhl_pkg::S_CLR: begin
				if (clr_q == AW'(fhhl_pkg::COLS - 1)) state_d = fhhl_pkg::S_IDLE;
			end
			fhhl_pkg::S_IDLE: if (item_acc) state_d = fhhl_pkg::S_DECODE;
			fhhl_pkg::S_DECODE: begin
				if (item_q.opcode == fhhl_pkg::OP_CLEAR) state_d = fhhl_pkg::S_CLR;
				else if (item_q.start_x == item_q.end_x) state_d = fhhl_pkg::S_SW_X;
				else if (too_many) state_d = fhhl_pkg::S_ERR;
				else state_d = fhhl_pkg::S_P_CLS;
			end
			fhhl_pkg::S_P_CLS:     state_d = fhhl_pkg::S_STEP;
			fhhl_pkg::S_STEP:      state_d = fhhl_pkg::S_STEP_WAIT;
			fhhl_pkg::S_STEP_WAIT: if (div_rsp.done) state_d = fhhl_pkg::S_C_RD;
			fhhl_pkg::S_C_RD:      state_d = fhhl_pkg::S_C_CLS;
			fhhl_pkg::S_C_CLS: begin
				case (mode_d)
					fhhl_pkg::MD_NONE:   state_d = fhhl_pkg::S_ADV;
					fhhl_pkg::MD_DIRECT: state_d = fhhl_pkg::S_EMIT;
					default:             state_d = fhhl_pkg::S_CR_RD0;
				endcase
			end
			fhhl_pkg::S_CR_RD0:  state_d = fhhl_pkg::S_CR_CHK0;
			fhhl_pkg::S_CR_CHK0: state_d = chk0_hit ? fhhl_pkg::S_EMIT : fhhl_pkg::S_CR_NEXT;
			fhhl_pkg::S_CR_NEXT: state_d = fhhl_pkg::S_CR_WAIT;
			fhhl_pkg::S_CR_WAIT: if (div_rsp.done) state_d = fhhl_pkg::S_CR_RD;
			fhhl_pkg::S_CR_RD:   state_d = fhhl_pkg::S_CR_CHK;
			fhhl_pkg::S_CR_CHK:  state_d = chk_term ? fhhl_pkg::S_EMIT : fhhl_pkg::S_CR_NEXT;
			fhhl_pkg::S_EMIT:    if (push_ok) state_d = fhhl_pkg::S_SW_X;
			fhhl_pkg::S_SW_X: begin
				state_d = sw_need_div ? fhhl_pkg::S_SW_WAIT : fhhl_pkg::S_SW_RD;
			end
			fhhl_pkg::S_SW_WAIT: if (div_rsp.done) state_d = fhhl_pkg::S_SW_RD;
			fhhl_pkg::S_SW_RD:   state_d = fhhl_pkg::S_SW_WR;
			fhhl_pkg::S_SW_WR: begin
				state_d = (sw_x_q == eb_x_q) ? fhhl_pkg::S_AFTER : fhhl_pkg::S_SW_X;
			end
			fhhl_pkg::S_AFTER: begin
				if (vert_q) state_d = fhhl_pkg::S_FIN;
				else if (mode_q == fhhl_pkg::MD_DOUBLE && !ph_q) state_d = fhhl_pkg::S_CR_RD0;
				else state_d = fhhl_pkg::S_ADV;
			end
			fhhl_pkg::S_ADV: state_d = fin_q ? fhhl_pkg::S_FIN : fhhl_pkg::S_STEP;
			fhhl_pkg::S_FIN: if (!pend_v_q || out_free) state_d = fhhl_pkg::S_IDLE;
			fhhl_pkg::S_ERR: if (out_free) state_d = fhhl_pkg::S_IDLE;
			default:         state_d = fhhl_pkg::S_IDLE;
		endcase
	end

	// outputs: handshakes, memory port, divider request
	always_comb begin
		cfg_ready   = 1'b1;
		item_stall  = state_q != fhhl_pkg::S_IDLE;
		item_acc    = item_valid && !item_stall;
		piece_valid = out_v_q;
		piece       = out_q;

		case (state_q)
			fhhl_pkg::S_CLR:    ram_addr = clr_q;
			fhhl_pkg::S_DECODE: ram_addr = item_q.start_x;
			fhhl_pkg::S_C_RD:   ram_addr = cx_q;
			fhhl_pkg::S_CR_RD:  ram_addr = cr_x_q;
			fhhl_pkg::S_SW_RD:  ram_addr = sw_x_q;
			fhhl_pkg::S_SW_WR:  ram_addr = sw_x_q;
			default:            ram_addr = px_q;
		endcase
		ram_we = (state_q == fhhl_pkg::S_CLR) || (state_q == fhhl_pkg::S_SW_WR);
		if (state_q == fhhl_pkg::S_CLR) begin
			up_wd = '0;
			lo_wd = HZ_W'(SCREEN_SIZE);
		end else begin
			up_wd = (HZ_W'(sw_y_q) > up_rd) ? HZ_W'(sw_y_q) : up_rd;
			lo_wd = (HZ_W'(sw_y_q) < lo_rd) ? HZ_W'(sw_y_q) : lo_rd;
		end

		div_req.start = 1'b0;
		div_req.xa    = item_q.start_x;
		div_req.ya    = item_q.start_y;
		div_req.xb    = item_q.end_x;
		div_req.yb    = item_q.end_y;
		div_req.x     = step_cx;
		case (state_q)
			fhhl_pkg::S_STEP: div_req.start = 1'b1;
			fhhl_pkg::S_CR_NEXT: begin
				div_req.start = 1'b1;
				div_req.xa    = px_q;
				div_req.ya    = py_q;
				div_req.xb    = cx_q;
				div_req.yb    = cy_q;
				div_req.x     = cr_nx;
			end
			fhhl_pkg::S_SW_X: begin
				div_req.start = sw_need_div;
				div_req.xa    = ea_x_q;
				div_req.ya    = ea_y_q;
				div_req.xb    = eb_x_q;
				div_req.yb    = eb_y_q;
				div_req.x     = sw_x_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fhhl_pkg::S_CLR;
			inc_q    <= IW'(1);
			clr_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) inc_q <= cfg_data;
			if (state_q == fhhl_pkg::S_CLR) clr_q <= clr_q + 1'b1;
			else if (state_q == fhhl_pkg::S_DECODE) clr_q <= '0;
			if (state_q == fhhl_pkg::S_EMIT && push_ok) pend_v_q <= 1'b1;
			else if (state_q == fhhl_pkg::S_FIN && out_free) pend_v_q <= 1'b0;
			if (out_load) out_v_q <= 1'b1;
			else if (!piece_stall) out_v_q <= 1'b0;
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		if (out_load) out_q <= out_next;
		case (state_q)
			fhhl_pkg::S_IDLE: if (item_acc) item_q <= item;
			fhhl_pkg::S_DECODE: begin
				px_q   <= item_q.start_x;
				py_q   <= item_q.start_y;
				dir_q  <= item_q.end_x > item_q.start_x;
				vert_q <= item_q.end_x == item_q.start_x;
				ea_x_q <= item_q.end_x;
				ea_y_q <= item_q.end_y;
				eb_x_q <= item_q.end_x;
				eb_y_q <= item_q.end_y;
				sw_x_q <= item_q.end_x;
			end
			fhhl_pkg::S_P_CLS: pf_q <= cls;
			fhhl_pkg::S_STEP: begin
				cx_q  <= step_cx;
				fin_q <= step_fin;
			end
			fhhl_pkg::S_STEP_WAIT: if (div_rsp.done) cy_q <= div_rsp.y;
			fhhl_pkg::S_C_CLS: begin
				cf_q     <= cls;
				mode_q   <= mode_d;
				form_q   <= form_d;
				hz_sel_q <= hz0_d;
				hz1_q    <= hz1_d;
				ph_q     <= 1'b0;
			end
			fhhl_pkg::S_CR_CHK0: begin
				ix_q   <= px_q;
				iy_q   <= py_q;
				side_q <= HZ_W'(py_q) >= hz_rd;
				cr_x_q <= px_q;
			end
			fhhl_pkg::S_CR_NEXT: cr_x_q <= cr_nx;
			fhhl_pkg::S_CR_WAIT: if (div_rsp.done) cr_y_q <= div_rsp.y;
			fhhl_pkg::S_CR_CHK: begin
				ix_q <= cr_x_q;
				iy_q <= cr_y_q;
			end
			fhhl_pkg::S_EMIT: begin
				if (push_ok) begin
					pend_q <= emit_piece;
					ea_x_q <= emit_piece.piece_x0;
					ea_y_q <= emit_piece.piece_y0;
					eb_x_q <= emit_piece.piece_x1;
					eb_y_q <= emit_piece.piece_y1;
					sw_x_q <= emit_piece.piece_x0;
				end
			end
			fhhl_pkg::S_SW_X: begin
				if (sw_x_q == eb_x_q) sw_y_q <= eb_y_q;
				else if (sw_x_q == ea_x_q) sw_y_q <= ea_y_q;
			end
			fhhl_pkg::S_SW_WAIT: if (div_rsp.done) sw_y_q <= div_rsp.y;
			fhhl_pkg::S_SW_WR: if (sw_x_q != eb_x_q) sw_x_q <= sw_nx;
			fhhl_pkg::S_AFTER: begin
				if (mode_q == fhhl_pkg::MD_DOUBLE && !ph_q) begin
					ph_q     <= 1'b1;
					form_q   <= fhhl_pkg::FM_IC;
					hz_sel_q <= hz1_q;
				end
			end
			fhhl_pkg::S_ADV: begin
				px_q <= cx_q;
				py_q <= cy_q;
				pf_q <= cf_q;
			end
			default: begin
			end
		endcase
	end

	// checks
	`FHHL_ASSERT_NOW(a_div_start_idle, clk, arst_n, div_req.start, !div_rsp.busy)
	`FHHL_ASSERT_NOW(a_idle_no_pending, clk, arst_n, state_q == fhhl_pkg::S_IDLE, !pend_v_q)
	`FHHL_ASSERT_NEXT(a_err_request, clk, arst_n, (state_q == fhhl_pkg::S_ERR) && out_free, piece_valid && piece.span_error && piece.last_piece)

endmodule

/* sv/fhhl_ram.sv */
module fhhl_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/fhhl_interp.sv */
module fhhl_interp (
	input  logic               clk,
	input  logic               arst_n,
	input  fhhl_pkg::div_req_t req,
	output fhhl_pkg::div_rsp_t rsp
);

	localparam int CW    = fhhl_pkg::COORD_W;
	localparam int NUM_W = fhhl_pkg::DIV_NUM_W;
	localparam int DEN_W = fhhl_pkg::DIV_DEN_W;
	localparam int CNT_W = $clog2(NUM_W);

	fhhl_pkg::div_state_t state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;

	logic signed [CW:0]     dy_q, xo_q, d_q;
	logic [CW-1:0]          ya_q;
	logic signed [NUM_W-1:0] prod_q;
	logic [NUM_W-1:0]       num_q, quo_q;
	logic [DEN_W-1:0]       den_q, rem_q;
	logic                   neg_q;

	logic [NUM_W-1:0] an;
	logic [CW:0]      ad_w;
	logic [NUM_W-1:0] num_init;
	logic [DEN_W:0]   trial, rem_sub;
	logic             ge;
	logic [CW:0]      q_lo, sum;

	// magnitudes and rounding bias: (2|n| + |d|) / (2|d|)
	always_comb begin
		an       = prod_q[NUM_W-1] ? NUM_W'(-prod_q) : NUM_W'(prod_q);
		ad_w     = d_q[CW] ? (CW+1)'(-d_q) : (CW+1)'(d_q);
		num_init = {an[NUM_W-2:0], 1'b0} + NUM_W'(ad_w[CW-1:0]);
		trial    = {rem_q, num_q[NUM_W-1]};
		ge       = trial >= {1'b0, den_q};
		rem_sub  = ge ? (trial - {1'b0, den_q}) : trial;
		q_lo     = quo_q[CW:0];
		sum      = {1'b0, ya_q} + (neg_q ? (CW+1)'(-q_lo) : q_lo);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fhhl_pkg::DV_IDLE: if (req.start) state_d = fhhl_pkg::DV_MUL;
			fhhl_pkg::DV_MUL:  state_d = fhhl_pkg::DV_PREP;
			fhhl_pkg::DV_PREP: state_d = fhhl_pkg::DV_ITER;
			fhhl_pkg::DV_ITER: begin
				if (cnt_q == CNT_W'(NUM_W - 1)) state_d = fhhl_pkg::DV_DONE;
			end
			fhhl_pkg::DV_DONE: state_d = fhhl_pkg::DV_IDLE;
			default:           state_d = fhhl_pkg::DV_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rsp.busy = state_q != fhhl_pkg::DV_IDLE;
		rsp.done = state_q == fhhl_pkg::DV_DONE;
		rsp.y    = sum[CW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fhhl_pkg::DV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == fhhl_pkg::DV_PREP) cnt_q <= '0;
			else if (state_q == fhhl_pkg::DV_ITER) cnt_q <= cnt_q + 1'b1;
		end
	end

	// operand capture, product, restoring division one bit a cycle
	always_ff @(posedge clk) begin
		case (state_q)
			fhhl_pkg::DV_IDLE: begin
				if (req.start) begin
					dy_q <= $signed({1'b0, req.yb}) - $signed({1'b0, req.ya});
					xo_q <= $signed({1'b0, req.x}) - $signed({1'b0, req.xa});
					d_q  <= $signed({1'b0, req.xb}) - $signed({1'b0, req.xa});
					ya_q <= req.ya;
				end
			end
			fhhl_pkg::DV_MUL: begin
				prod_q <= dy_q * xo_q;
				neg_q  <= dy_q[CW] ^ xo_q[CW] ^ d_q[CW];
			end
			fhhl_pkg::DV_PREP: begin
				num_q <= num_init;
				den_q <= {ad_w[CW-1:0], 1'b0};
				rem_q <= '0;
				quo_q <= '0;
			end
			fhhl_pkg::DV_ITER: begin
				rem_q <= rem_sub[DEN_W-1:0];
				num_q <= {num_q[NUM_W-2:0], 1'b0};
				quo_q <= {quo_q[NUM_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

endmodule

/* bench/tb_floating_horizon_hidden_line.sv */
`timescale 1ns / 100ps

// expected visible pieces, worked out from a private copy of both horizons
class HorizonScoreboard;
	fhhl_pkg::piece_t pending_pieces[$];
	int     upper_hz[fhhl_pkg::COLS];
	int     lower_hz[fhhl_pkg::COLS];
	int     step_inc;
	bit     failed;

	function new();
		step_inc = 1;
		failed   = 0;
		wipe_horizons();
	endfunction

	function void wipe_horizons();
		for (int i = 0; i < fhhl_pkg::COLS; i++) begin
			upper_hz[i] = 0;
			lower_hz[i] = 1024;
		end
	endfunction

	// exact division, rounded half away from zero
	function int round_div(int n, int d);
		int an, ad, q;
		an = (n < 0) ? -n : n;
		ad = (d < 0) ? -d : d;
		q  = (2 * an + ad) / (2 * ad);
		return ((n < 0) != (d < 0)) ? -q : q;
	endfunction

	function int row_at(int xa, int ya, int xb, int yb, int x);
		return ya + round_div((yb - ya) * (x - xa), xb - xa);
	endfunction

	function fhhl_pkg::cls_t classify(int x, int y);
		int u, l;
		u = upper_hz[x & 1023];
		l = lower_hz[x & 1023];
		if (y < u && y > l) return fhhl_pkg::CL_HIDDEN;
		if (y >= u) return fhhl_pkg::CL_ABOVE;
		return fhhl_pkg::CL_BELOW;
	endfunction

	function void raise_column(int x, int y);
		if (y > upper_hz[x & 1023]) upper_hz[x & 1023] = y;
		if (y < lower_hz[x & 1023]) lower_hz[x & 1023] = y;
	endfunction

	function void raise_along(int xa, int ya, int xb, int yb);
		int s;
		if (xa == xb) begin
			raise_column(xb, yb);
			return;
		end
		s = (xb > xa) ? 1 : -1;
		for (int x = xa; x != xb; x += s) raise_column(x, row_at(xa, ya, xb, yb, x));
		raise_column(xb, yb);
	endfunction

	function int horizon(fhhl_pkg::hz_sel_t sel, int x);
		return (sel == fhhl_pkg::HZ_UPPER) ? upper_hz[x & 1023] : lower_hz[x & 1023];
	endfunction

	// column by column search for where the line crosses one horizon
	function void find_crossing(int xa, int ya, int xb, int yb, fhhl_pkg::hz_sel_t sel,
			output int xo, output int yo);
		int s, x, y;
		bit side, now_side;
		if (xa == xb) begin
			xo = xb;
			yo = horizon(sel, xb);
			return;
		end
		if (ya == horizon(sel, xa)) begin
			xo = xa;
			yo = ya;
			return;
		end
		s    = (xb > xa) ? 1 : -1;
		side = ya >= horizon(sel, xa);
		x    = xa;
		y    = ya;
		do begin
			x += s;
			y = row_at(xa, ya, xb, yb, x);
			now_side = y >= horizon(sel, x);
		end while (now_side == side && x != xb);
		xo = x;
		yo = y;
	endfunction

	function void add_piece(ref fhhl_pkg::piece_t found[$], input int xa, int ya, int xb,
			int yb);
		fhhl_pkg::piece_t p;
		if (found.size() < 64) begin
			p = '0;
			p.piece_x0 = xa[9:0];
			p.piece_y0 = ya[9:0];
			p.piece_x1 = xb[9:0];
			p.piece_y1 = yb[9:0];
			found.push_back(p);
		end
		raise_along(xa, ya, xb, yb);
	endfunction

	// accepted request: walk the segment and queue its visible pieces
	function void note_request(fhhl_pkg::item_t it);
		int x1, y1, x2, y2, inc, dx, adx, s, px, py, cx, cy, ix, iy;
		fhhl_pkg::cls_t pc, cc;
		bit done;
		fhhl_pkg::piece_t found[$];
		fhhl_pkg::piece_t p;
		x1 = it.start_x;
		y1 = it.start_y;
		x2 = it.end_x;
		y2 = it.end_y;
		inc = (step_inc == 0) ? 1 : step_inc;
		dx = x2 - x1;
		if (it.opcode == fhhl_pkg::OP_CLEAR) begin
			wipe_horizons();
			return;
		end
		if (dx == 0) begin
			raise_column(x2, y2);
			return;
		end
		adx = (dx < 0) ? -dx : dx;
		if ((adx + inc - 1) / inc > 32) begin
			p = '0;
			p.last_piece = 1'b1;
			p.span_error = 1'b1;
			pending_pieces.push_back(p);
			return;
		end
		s = (dx < 0) ? -inc : inc;
		px = x1;
		py = y1;
		pc = classify(px, py);
		done = 0;
		while (!done) begin
			cx = px + s;
			if ((s > 0 && cx >= x2) || (s < 0 && cx <= x2)) begin
				cx = x2;
				done = 1;
			end
			cy = row_at(x1, y1, x2, y2, cx);
			cc = classify(cx, cy);
			if (cc == pc) begin
				if (cc != fhhl_pkg::CL_HIDDEN) add_piece(found, px, py, cx, cy);
			end else if (cc == fhhl_pkg::CL_HIDDEN) begin
				find_crossing(px, py, cx, cy,
					(pc == fhhl_pkg::CL_ABOVE) ? fhhl_pkg::HZ_UPPER : fhhl_pkg::HZ_LOWER,
					ix, iy);
				add_piece(found, px, py, ix, iy);
			end else if (pc == fhhl_pkg::CL_HIDDEN) begin
				// hidden then visible: cut at the horizon being entered
				find_crossing(px, py, cx, cy,
					(cc == fhhl_pkg::CL_ABOVE) ? fhhl_pkg::HZ_UPPER : fhhl_pkg::HZ_LOWER,
					ix, iy);
				add_piece(found, ix, iy, cx, cy);
			end else if (cc == fhhl_pkg::CL_ABOVE) begin
				find_crossing(px, py, cx, cy, fhhl_pkg::HZ_LOWER, ix, iy);
				add_piece(found, px, py, ix, iy);
				find_crossing(px, py, cx, cy, fhhl_pkg::HZ_UPPER, ix, iy);
				add_piece(found, ix, iy, cx, cy);
			end else begin
				find_crossing(px, py, cx, cy, fhhl_pkg::HZ_UPPER, ix, iy);
				add_piece(found, px, py, ix, iy);
				find_crossing(px, py, cx, cy, fhhl_pkg::HZ_LOWER, ix, iy);
				add_piece(found, ix, iy, cx, cy);
			end
			px = cx;
			py = cy;
			pc = cc;
		end
		if (found.size() > 0) found[found.size() - 1].last_piece = 1'b1;
		foreach (found[k]) pending_pieces.push_back(found[k]);
	endfunction

	// one piece handed over by the block
	function void check_piece(fhhl_pkg::piece_t got);
		fhhl_pkg::piece_t want;
		if (pending_pieces.size() == 0) begin
			$error("unexpected piece %p", got);
			failed = 1;
			return;
		end
		want = pending_pieces.pop_front();
		if (got.piece_x0 !== want.piece_x0) begin
			$error("piece_x0 expected %0d got %0d", want.piece_x0, got.piece_x0);
			failed = 1;
		end
		if (got.piece_y0 !== want.piece_y0) begin
			$error("piece_y0 expected %0d got %0d", want.piece_y0, got.piece_y0);
			failed = 1;
		end
		if (got.piece_x1 !== want.piece_x1) begin
			$error("piece_x1 expected %0d got %0d", want.piece_x1, got.piece_x1);
			failed = 1;
		end
		if (got.piece_y1 !== want.piece_y1) begin
			$error("piece_y1 expected %0d got %0d", want.piece_y1, got.piece_y1);
			failed = 1;
		end
		if (got.last_piece !== want.last_piece) begin
			$error("last_piece expected %0d got %0d", want.last_piece, got.last_piece);
			failed = 1;
		end
		if (got.span_error !== want.span_error) begin
			$error("span_error expected %0d got %0d", want.span_error, got.span_error);
			failed = 1;
		end
	endfunction
endclass

module tb_floating_horizon_hidden_line;
	localparam int SETTLE_CYCLES = 40000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [fhhl_pkg::INC_W-1:0] cfg_data = '0;
	logic                       item_valid = 1'b0;
	logic                       item_stall;
	fhhl_pkg::item_t            item = '0;
	logic                       piece_valid;
	logic                       piece_stall = 1'b0;
	fhhl_pkg::piece_t           piece;

	int idle_pct = 0;
	int stall_pct = 0;

	HorizonScoreboard sb = new();

	floating_horizon_hidden_line dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.piece_valid(piece_valid),
		.piece_stall(piece_stall),
		.piece      (piece)
	);

	always #6 clk = ~clk;

	// receiver back-pressure
	always @(posedge clk) begin
		piece_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && piece_valid && !piece_stall) sb.check_piece(piece);
	end

	// overall time limit
	initial begin
		#1s;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic send_request(fhhl_pkg::item_t req);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= req;
		do @(posedge clk); while (item_stall);
		sb.note_request(req);
	endtask

	task automatic draw(int x1, int y1, int x2, int y2);
		fhhl_pkg::item_t r;
		r.opcode  = fhhl_pkg::OP_DRAW;
		r.start_x = fhhl_pkg::COORD_W'(x1);
		r.start_y = fhhl_pkg::COORD_W'(y1);
		r.end_x   = fhhl_pkg::COORD_W'(x2);
		r.end_y   = fhhl_pkg::COORD_W'(y2);
		send_request(r);
	endtask

	task automatic clear_horizons();
		fhhl_pkg::item_t r;
		r = $bits(fhhl_pkg::item_t)'({$urandom, $urandom});
		r.opcode = fhhl_pkg::OP_CLEAR;
		send_request(r);
	endtask

	// wait until all pieces are out and the block has finished its work
	task automatic settle();
		item_valid <= 1'b0;
		while (sb.pending_pieces.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_increment(int v);
		cfg_valid <= 1'b1;
		cfg_data  <= fhhl_pkg::INC_W'(v);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.step_inc = v & 1023;
	endtask

	// random clear, vertical or segment: mostly short, some long or too long
	task automatic random_request(int inc);
		int r, eff, adx, x1, x2, y1, y2, reach;
		eff = (inc == 0) ? 1 : inc;
		reach = (eff * 32 > 1023) ? 1023 : eff * 32;
		r = $urandom_range(0, 99);
		if (r < 5) begin
			clear_horizons();
			return;
		end
		if (r < 12) adx = 0;
		else if (r < 20 && eff * 32 < 1023) adx = $urandom_range(eff * 32 + 1, 1023);
		else if (r < 28) adx = $urandom_range(1, reach);
		else adx = $urandom_range(1, (reach < 40) ? reach : 40);
		x1 = $urandom_range(0, 1023 - adx);
		x2 = x1 + adx;
		if ($urandom_range(0, 1)) begin
			r = x1;
			x1 = x2;
			x2 = r;
		end
		y1 = $urandom_range(0, 1023);
		if ($urandom_range(0, 2) == 0) y2 = $urandom_range(0, 1023);
		else begin
			y2 = y1 + $urandom_range(0, 120) - 60;
			if (y2 < 0) y2 = 0;
			if (y2 > 1023) y2 = 1023;
		end
		draw(x1, y1, x2, y2);
	endtask

	initial begin
		int incs[6] = '{1, 0, 1023, 5, 32, 2};
		int counts[6] = '{22, 18, 8, 18, 18, 18};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 6; ph++) begin
			if (ph < 2) begin
				idle_pct = 20;
				stall_pct = 86;
			end else if (ph < 4) begin
				idle_pct = 86;
				stall_pct = 20;
			end else begin
				idle_pct = 0;
				stall_pct = 0;
			end
			if (ph > 0) settle();
			write_increment(incs[ph]);

			if (ph == 0) begin
				// directed: extremes, clear, vertical, horizon crossings
				draw(0, 0, 31, 1023);
				draw(1023, 1023, 992, 0);
				draw(0, 0, 1023, 0);
				clear_horizons();
				draw(500, 1023, 500, 0);
				draw(100, 500, 120, 500);
				draw(100, 300, 120, 300);
				// hidden then visible above
				draw(100, 400, 120, 700);
				clear_horizons();
				draw(100, 500, 120, 500);
				draw(100, 300, 120, 300);
				// hidden then visible below
				draw(100, 400, 120, 100);
				// entirely hidden
				draw(102, 350, 118, 420);
				// above to below through the hidden band, then hidden to above
				draw(100, 900, 120, 0);
				draw(120, 10, 100, 1000);
				draw(300, 5, 300, 1023);
				clear_horizons();
			end
			for (int i = 0; i < counts[ph]; i++) random_request(incs[ph]);
		end

		settle();
		if (!sb.failed) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end
endmodule
